// File: hw/rtl/masked_byte_pattern_search_defines.svh
// ----------------------------------------------------------------------------
// masked_byte_pattern_search assertion macros
// Shared concurrent assertion forms for the pattern search RTL.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH

// same-cycle implication
`define MBPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// File: hw/rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants shared by the masked byte pattern search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbps_pkg;

   localparam int MAX_PATTERN_BYTES = 16;
   localparam int OFFSET_BITS       = 32;
   localparam int REG_BYTES         = 16;
   localparam int LEN_BITS          = 5;
   localparam int ALIGN_BITS        = 2;
   localparam int COUNT_BITS        = 16;
   localparam int CSR_DATA_BITS     = 64;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int WIN_IDX_BITS      = $clog2(MAX_PATTERN_BYTES);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MASK_LOW     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MASK_HIGH    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LENGTH       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ALIGN        = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LIMIT        = 3'd6;

   typedef struct packed {
      logic [REG_BYTES-1:0][7:0] pattern;
      logic [REG_BYTES-1:0][7:0] mask;
      logic [LEN_BITS-1:0]       length;
      logic [ALIGN_BITS-1:0]     align_log2;
      logic [COUNT_BITS-1:0]     limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] match_offset;
      logic                   match_valid;
      logic                   scan_done;
      logic [COUNT_BITS-1:0]  total_matches;
   } rsp_type;

endpackage

// File: hw/rtl/mbps_csr.sv
// ----------------------------------------------------------------------------
// mbps_csr
// Configuration registers: pattern, masks, length, alignment, result limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbps_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output mbps_pkg::cfg_type                      cfg
);

   mbps_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mbps_pkg::REG_PATTERN_LOW:  cfg_in.pattern[7:0]  = csr_wdata;
            mbps_pkg::REG_PATTERN_HIGH: cfg_in.pattern[15:8] = csr_wdata;
            mbps_pkg::REG_MASK_LOW:     cfg_in.mask[7:0]     = csr_wdata;
            mbps_pkg::REG_MASK_HIGH:    cfg_in.mask[15:8]    = csr_wdata;
            mbps_pkg::REG_LENGTH:
               cfg_in.length = csr_wdata[mbps_pkg::LEN_BITS-1:0];
            mbps_pkg::REG_ALIGN:
               cfg_in.align_log2 = csr_wdata[mbps_pkg::ALIGN_BITS-1:0];
            mbps_pkg::REG_LIMIT:
               cfg_in.limit = csr_wdata[mbps_pkg::COUNT_BITS-1:0];
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/mbps_scan.sv
// ----------------------------------------------------------------------------
// mbps_scan
// Input register, byte window, masked compare and scan position tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "masked_byte_pattern_search_defines.svh"

module mbps_scan (
   input  logic               clock,
   input  logic               reset,
   input  mbps_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  mbps_pkg::req_type  req_payload,
   input  logic               push_space,
   output logic               push_valid,
   output mbps_pkg::rsp_type  push_data
);

   localparam int W   = mbps_pkg::OFFSET_BITS;
   localparam int LB  = mbps_pkg::LEN_BITS;
   localparam int MPB = mbps_pkg::MAX_PATTERN_BYTES;
   localparam int CB  = mbps_pkg::COUNT_BITS;

   logic                  in_valid_ff;
   mbps_pkg::req_type     in_word_ff;

   logic [MPB-1:0][7:0]   window_ff, window_in;
   logic [W:0]            pos_ff, pos_in;
   logic [W-1:0]          next_start_ff, next_start_in;
   logic [CB-1:0]         count_ff, count_in;
   logic                  limit_ff, limit_in;

   logic                  advance;
   logic [MPB-1:0][7:0]   win_next;
   logic [LB-1:0]         eff_len;
   logic [2:0]            amask;
   logic [3:0]            align_val;
   logic                  cur_ok;
   logic [W:0]            diff;
   logic [W-1:0]          start;
   logic                  candidate;
   logic                  bytes_ok;
   logic                  found;
   logic [W:0]            end_raw;
   logic [W:0]            end_aligned;
   logic [W-1:0]          end_sat;
   logic [CB-1:0]         count_new;
   logic                  end_of_image;
   logic                  scan_idle;

   assign advance   = in_valid_ff && push_space;
   assign req_ready = !in_valid_ff || push_space;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_payload;
      end
   end

   always_comb begin
      win_next[0] = in_word_ff.data_byte;
      for (int k = 1; k < MPB; k++) begin
         win_next[k] = window_ff[k-1];
      end
   end

   // lengths above the pattern store size act as the store size
   always_comb begin
      eff_len = cfg.length;
      if (eff_len > LB'(mbps_pkg::REG_BYTES)) eff_len = LB'(mbps_pkg::REG_BYTES);
      if (eff_len > LB'(MPB)) eff_len = LB'(MPB);
   end

   assign align_val = 4'd1 << cfg.align_log2;
   assign amask     = 3'(align_val - 4'd1);

   assign cur_ok = !pos_ff[W];
   // bit W set means the candidate start would be negative
   assign diff   = {1'b0, pos_ff[W-1:0]} + (W+1)'(1) - (W+1)'(eff_len);
   assign start  = diff[W-1:0];

   assign candidate = cur_ok && (eff_len != '0) && !limit_ff && !diff[W] &&
                      ((start[2:0] & amask) == 3'd0) && (start >= next_start_ff);

   // pattern byte j lines up with window slot len-1-j
   always_comb begin
      logic [LB-1:0] slot;
      bytes_ok = 1'b1;
      for (int j = 0; j < MPB; j++) begin
         slot = eff_len - LB'(1) - LB'(j);
         if ((LB'(j) < eff_len) &&
             ((cfg.pattern[j] & cfg.mask[j]) !=
              (win_next[slot[mbps_pkg::WIN_IDX_BITS-1:0]] & cfg.mask[j]))) begin
            bytes_ok = 1'b0;
         end
      end
   end

   assign found = advance && candidate && bytes_ok;

   // next candidate: end of match rounded up to alignment, saturated
   assign end_raw     = {1'b0, start} + (W+1)'(eff_len) + (W+1)'(amask);
   assign end_aligned = end_raw & ~((W+1)'(amask));
   assign end_sat     = end_aligned[W] ? '1 : end_aligned[W-1:0];

   assign count_new = (found && (count_ff != mbps_pkg::COUNT_MAX)) ?
                      count_ff + CB'(1) : count_ff;

   always_comb begin
      window_in     = window_ff;
      pos_in        = pos_ff;
      next_start_in = next_start_ff;
      count_in      = count_ff;
      limit_in      = limit_ff;
      if (advance) begin
         if (in_word_ff.last_byte) begin
            window_in     = '0;
            pos_in        = '0;
            next_start_in = '0;
            count_in      = '0;
            limit_in      = 1'b0;
         end else begin
            window_in = win_next;
            if (cur_ok) pos_in = pos_ff + (W+1)'(1);
            if (found) begin
               next_start_in = end_sat;
               count_in      = count_new;
               if ((cfg.limit != '0) && (count_new >= cfg.limit)) limit_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         pos_ff        <= '0;
         next_start_ff <= '0;
         count_ff      <= '0;
         limit_ff      <= 1'b0;
      end else begin
         window_ff     <= window_in;
         pos_ff        <= pos_in;
         next_start_ff <= next_start_in;
         count_ff      <= count_in;
         limit_ff      <= limit_in;
      end
   end

   assign push_valid = advance && (found || in_word_ff.last_byte);

   always_comb begin
      push_data               = '0;
      push_data.match_offset  = found ? start : '0;
      push_data.match_valid   = found;
      push_data.scan_done     = in_word_ff.last_byte;
      push_data.total_matches = count_new;
   end

   assign end_of_image = advance && in_word_ff.last_byte;
   assign scan_idle    = (pos_ff == '0) && (count_ff == '0) && !limit_ff;

   `MBPS_ASSERT_NOW(a_match_needs_length, clock, reset, found, eff_len != '0)
   `MBPS_ASSERT_NOW(a_match_aligned, clock, reset, found, (start[2:0] & amask) == 3'd0)
   `MBPS_ASSERT_NEXT(a_last_clears_scan, clock, reset, end_of_image, scan_idle)

endmodule

// File: hw/rtl/mbps_out_buf.sv
// ----------------------------------------------------------------------------
// mbps_out_buf
// Result register with one skid entry between the scan logic and rsp port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "masked_byte_pattern_search_defines.svh"

module mbps_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  mbps_pkg::rsp_type  push_data,
   output logic               push_space,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mbps_pkg::rsp_type  rsp_payload
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   mbps_pkg::rsp_type out_word_ff, out_word_in;
   mbps_pkg::rsp_type skid_word_ff, skid_word_in;
   logic              pop;
   logic              out_stall;

   assign pop        = out_valid_ff && rsp_ready;
   assign push_space = !(out_valid_ff && skid_valid_ff);
   assign out_stall  = out_valid_ff && !rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            out_valid_in  = 1'b1;
            skid_word_in  = push_data;
            skid_valid_in = push_valid;
         end else begin
            out_word_in  = push_data;
            out_valid_in = push_valid;
         end
      end else if (push_valid) begin
         skid_word_in  = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_word_ff;

   `MBPS_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `MBPS_ASSERT_NOW(a_no_push_when_full, clock, reset, push_valid, !(out_valid_ff && skid_valid_ff))
   `MBPS_ASSERT_NEXT(a_rsp_held, clock, reset, out_stall, out_valid_ff && $stable(out_word_ff))

endmodule

// File: hw/rtl/masked_byte_pattern_search.sv
// Path: a word accepted on req is held in the input register, then its result is
//   registered in the result register (or skid entry) before rsp_valid rises.
// Throughput: one word per cycle while the result buffer has space; the masked
//   compare over the 16-byte window and the position update lie between the registers.
// Reset: synchronous, active high; clears scan state, buffers and all config registers.
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Streams an image byte per word and reports aligned masked pattern matches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module masked_byte_pattern_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mbps_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mbps_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   mbps_pkg::cfg_type cfg;
   logic              push_valid;
   logic              push_space;
   mbps_pkg::rsp_type push_data;

   mbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbps_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_space  (push_space),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   mbps_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .push_space  (push_space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: dv/tb_masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_search
// Self-checking bench for the masked byte pattern search. A queue-fed driver
// streams image bytes, an in-bench predictor tracks the window, alignment,
// non-overlap, result limit and counter, and a monitor checks every result
// word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_masked_byte_pattern_search;

   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_WORDS   = 1600;
   localparam int PHASE_WORDS    = 210;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_REPORTS    = 100;
   localparam longint unsigned OFFSET_SPAN = 64'd1 << mbps_pkg::OFFSET_BITS;

   logic                                clock;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_ready;
   mbps_pkg::req_type                   req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_ready   = 1'b0;
   mbps_pkg::rsp_type                   rsp_payload;
   logic                                csr_wr_en   = 1'b0;
   logic [mbps_pkg::CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [mbps_pkg::CSR_DATA_BITS-1:0]  csr_wdata   = '0;

   // predictor state and its copy of the registers
   mbps_pkg::cfg_type               scan_cfg    = '0;
   logic [7:0]                      win_bytes [mbps_pkg::MAX_PATTERN_BYTES] = '{default: '0};
   longint unsigned                 scan_pos    = 0;
   longint unsigned                 next_start  = 0;
   logic [mbps_pkg::COUNT_BITS-1:0] hit_count   = '0;
   bit                              hits_capped = 1'b0;

   mbps_pkg::req_type         pending_words [$];
   mbps_pkg::rsp_type         expected_reports [$];
   int unsigned               words_queued    = 0;
   int unsigned               words_taken     = 0;
   int unsigned               results_checked = 0;
   int unsigned               match_reports   = 0;
   int unsigned               search_settings = 0;
   int unsigned               failures        = 0;
   int unsigned               stall_cycles    = 0;
   bit                        gaps_on         = 1'b1;

   masked_byte_pattern_search u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pattern_span();
      int unsigned span;
      span = scan_cfg.length;
      if (span > mbps_pkg::REG_BYTES) span = mbps_pkg::REG_BYTES;
      if (span > mbps_pkg::MAX_PATTERN_BYTES) span = mbps_pkg::MAX_PATTERN_BYTES;
      return span;
   endfunction

   // advance the scan by one accepted byte and queue the result it causes
   function automatic void predict_scan(mbps_pkg::req_type word);
      int unsigned       span, j, k;
      longint unsigned   step, cur, start, stop;
      logic [7:0]        m;
      bit                found, ok;
      mbps_pkg::rsp_type rsp;
      span  = pattern_span();
      step  = 64'd1 << scan_cfg.align_log2;
      found = 1'b0;
      start = 0;
      for (k = mbps_pkg::MAX_PATTERN_BYTES - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = word.data_byte;
      if (scan_pos < OFFSET_SPAN) begin
         cur = scan_pos;
         scan_pos++;
         if (span != 0 && !hits_capped && cur + 1 >= span) begin
            start = cur + 1 - span;
            if ((start & (step - 1)) == 0 && start >= next_start) begin
               ok = 1'b1;
               for (j = 0; j < span; j++) begin
                  m = scan_cfg.mask[j];
                  if ((scan_cfg.pattern[j] & m) != (win_bytes[span-1-j] & m)) ok = 1'b0;
               end
               if (ok) begin
                  found = 1'b1;
                  // next candidate: first aligned start at or past the match end
                  stop = (start + span + step - 1) & ~(step - 1);
                  if (stop > OFFSET_SPAN - 1) stop = OFFSET_SPAN - 1;
                  next_start = stop;
                  if (hit_count != mbps_pkg::COUNT_MAX) hit_count++;
                  if (scan_cfg.limit != 0 && hit_count >= scan_cfg.limit) hits_capped = 1'b1;
               end
            end
         end
      end
      if (found || word.last_byte) begin
         rsp.match_offset  = found ? 32'(start) : '0;
         rsp.match_valid   = found;
         rsp.scan_done     = word.last_byte;
         rsp.total_matches = hit_count;
         expected_reports.insert(expected_reports.size(), rsp);
      end
      if (word.last_byte) begin
         win_bytes   = '{default: '0};
         scan_pos    = 0;
         next_start  = 0;
         hit_count   = '0;
         hits_capped = 1'b0;
      end
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         failures++;
         // keep the log bounded if the block is badly broken
         if (failures <= MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      end
   endfunction

   function automatic void queue_word(logic [7:0] data, bit last);
      pending_words.insert(pending_words.size(),
                           mbps_pkg::req_type'{data_byte: data, last_byte: last});
      words_queued++;
   endfunction

   // one image: random background, pattern copies planted at random offsets,
   // some of them spoiled in a compared bit
   function automatic void queue_image(int unsigned n, bit close);
      logic [7:0]  img [];
      int unsigned span, p, j;
      img  = new[n];
      span = pattern_span();
      foreach (img[i])
         img[i] = ($urandom_range(99) < 50) ? 8'($urandom)
                                            : scan_cfg.pattern[$urandom_range(15)];
      p = 0;
      while (p + span <= n) begin
         if (span != 0 && $urandom_range(99) < 40) begin
            for (j = 0; j < span; j++)
               img[p+j] = (scan_cfg.pattern[j] & scan_cfg.mask[j])
                        | (8'($urandom) & ~scan_cfg.mask[j]);
            if ($urandom_range(99) < 20) begin
               j = $urandom_range(span - 1);
               img[p+j] ^= scan_cfg.mask[j] & 8'($urandom_range(1, 255));
            end
         end
         p += $urandom_range(1, span + 4);
      end
      for (j = 0; j < n; j++) queue_word(img[j], close && j == n - 1);
   endfunction

   task automatic write_reg(logic [mbps_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [mbps_pkg::CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         mbps_pkg::REG_PATTERN_LOW:  scan_cfg.pattern[7:0]  = value;
         mbps_pkg::REG_PATTERN_HIGH: scan_cfg.pattern[15:8] = value;
         mbps_pkg::REG_MASK_LOW:     scan_cfg.mask[7:0]     = value;
         mbps_pkg::REG_MASK_HIGH:    scan_cfg.mask[15:8]    = value;
         mbps_pkg::REG_LENGTH:       scan_cfg.length = value[mbps_pkg::LEN_BITS-1:0];
         mbps_pkg::REG_ALIGN:        scan_cfg.align_log2 = value[mbps_pkg::ALIGN_BITS-1:0];
         mbps_pkg::REG_LIMIT:        scan_cfg.limit = value[mbps_pkg::COUNT_BITS-1:0];
         default: ;
      endcase
   endtask

   // narrow registers get junk above their width, which must be dropped
   task automatic program_search(logic [63:0] pat_lo, pat_hi, mask_lo, mask_hi,
                                 int unsigned len, align, limit);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      write_reg(mbps_pkg::REG_PATTERN_LOW, pat_lo);
      write_reg(mbps_pkg::REG_PATTERN_HIGH, pat_hi);
      write_reg(mbps_pkg::REG_MASK_LOW, mask_lo);
      write_reg(mbps_pkg::REG_MASK_HIGH, mask_hi);
      write_reg(mbps_pkg::REG_LENGTH,
                {noise[63:mbps_pkg::LEN_BITS], mbps_pkg::LEN_BITS'(len)});
      write_reg(mbps_pkg::REG_ALIGN,
                {noise[63:mbps_pkg::ALIGN_BITS], mbps_pkg::ALIGN_BITS'(align)});
      write_reg(mbps_pkg::REG_LIMIT,
                {noise[63:mbps_pkg::COUNT_BITS], mbps_pkg::COUNT_BITS'(limit)});
      csr_wr_en <= 1'b0;
      search_settings++;
   endtask

   // every word sent and every result back, then let the pipeline empty
   task automatic wait_idle();
      while (words_taken != words_queued || expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_scan(req_payload);
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && !(gaps_on && $urandom_range(99) < 9)) begin
               req_valid   <= 1'b1;
               req_payload <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_reports.size() == 0) begin
               failures++;
               $error("unexpected result word: offset 0x%0h valid %0b done %0b total %0d",
                      rsp_payload.match_offset, rsp_payload.match_valid,
                      rsp_payload.scan_done, rsp_payload.total_matches);
            end else begin
               mbps_pkg::rsp_type want;
               want = expected_reports.pop_front();
               if (want.match_valid) match_reports++;
               check_field("match_offset", want.match_offset, rsp_payload.match_offset);
               check_field("match_valid", 32'(want.match_valid),
                           32'(rsp_payload.match_valid));
               check_field("scan_done", 32'(want.scan_done), 32'(rsp_payload.scan_done));
               check_field("total_matches", 32'(want.total_matches),
                           32'(rsp_payload.total_matches));
            end
         end
         rsp_ready <= gaps_on ? ($urandom_range(99) >= 9) : 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [127:0] pattern_bits, mask_bits;
      int unsigned  base, target, r, b, len, limit, phase_no, n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty pattern never matches; only the end-of-image word comes back
      program_search('0, '0, '1, '1, 0, 0, 0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b1);
      wait_idle();

      // run of identical bytes: two-byte matches must not overlap
      program_search(64'hAAAA, '0, 64'hFFFF, '0, 2, 0, 0);
      repeat (4) queue_word(8'hAA, 1'b0);
      queue_word(8'hAA, 1'b1);
      wait_idle();

      // length past 16 acts as 16, all wildcard, 8-byte alignment, top limit;
      // a one-byte image is too short, then match and end coincide
      program_search('1, '1, '0, '0, 31, 3, 16'hFFFF);
      queue_word(8'h5A, 1'b1);
      for (b = 0; b < 16; b++) queue_word(8'($urandom), b == 15);
      wait_idle();

      base     = words_queued;
      phase_no = 0;
      while (words_queued - base < RANDOM_WORDS) begin
         // two back-to-back phases run without any idling
         gaps_on <= !(phase_no == 3 || phase_no == 4);
         pattern_bits = {$urandom, $urandom, $urandom, $urandom};
         for (b = 0; b < 16; b++) begin
            r = $urandom_range(99);
            mask_bits[b*8 +: 8] = (r < 60) ? 8'hFF : (r < 80) ? 8'h00 : 8'($urandom);
         end
         if ($urandom_range(9) == 0) mask_bits = '0;
         r   = $urandom_range(99);
         len = (r < 5) ? 0 : (r < 65) ? $urandom_range(1, 6)
             : (r < 85) ? $urandom_range(7, 16) : $urandom_range(17, 31);
         r     = $urandom_range(99);
         limit = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 4)
               : (r < 95) ? $urandom_range(5, 40) : 65535;
         program_search(pattern_bits[63:0], pattern_bits[127:64],
                        mask_bits[63:0], mask_bits[127:64],
                        len, $urandom_range(3), limit);
         target = words_queued + PHASE_WORDS;
         while (words_queued < target) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
            // an unterminated image runs on into the next one
            queue_image(n, $urandom_range(99) < 92);
         end
         wait_idle();
         phase_no++;
      end

      $display("Scanned %0d words under %0d search settings, with random stalls on both sides.",
               words_taken, search_settings);
      $display("Checked %0d result words, %0d of them matches.", results_checked, match_reports);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
